>>> hw/rtl/ipv4_frame_forwarder_defines.svh
`ifndef IPV4_FRAME_FORWARDER_DEFINES_SVH
`define IPV4_FRAME_FORWARDER_DEFINES_SVH

// property that must hold on every clock edge out of reset
`define FWD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen out of reset
`define FWD_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/ipv4ff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv4ff_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int HDR_MAX       = 37;
  localparam int HCNT_W        = $clog2(HDR_MAX + 1);
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  // word offsets inside the buffered header
  localparam logic [HCNT_W-1:0] ETH_WORDS  = HCNT_W'(7);
  localparam logic [HCNT_W-1:0] IDX_TYPE   = HCNT_W'(6);
  localparam logic [HCNT_W-1:0] IDX_IHL    = HCNT_W'(7);
  localparam logic [HCNT_W-1:0] IDX_TTL    = HCNT_W'(11);
  localparam logic [HCNT_W-1:0] IDX_CSUM   = HCNT_W'(12);
  localparam logic [HCNT_W-1:0] IDX_DST_HI = HCNT_W'(15);
  localparam logic [HCNT_W-1:0] IDX_DST_LO = HCNT_W'(16);
  localparam logic [HCNT_W-1:0] IDX_SMAC0  = HCNT_W'(3);

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IHL_MIN       = 4'd5;
  localparam logic [1:0]  BYTES_ONE     = 2'd1;
  localparam logic [1:0]  BYTES_TWO     = 2'd2;
  localparam logic        ACT_FRAME     = 1'b0;
  localparam logic        ACT_ROUTE     = 1'b1;

  typedef enum logic [2:0] {
    F_COLLECT,
    F_PASS,
    F_DROP,
    F_LOOK,
    F_ISSUE
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD,
    B_WR
  } back_state_e;

  typedef struct packed {
    logic        action;
    logic [15:0] frame_word;
    logic        word_last;
    logic [1:0]  last_bytes;
    logic [3:0]  route_index;
    logic [31:0] route_addr;
    logic [47:0] route_mac;
    logic        route_valid;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic        out_last;
    logic [1:0]  out_bytes;
  } out_item_t;

  // queue entry: either one payload word or one header burst command
  typedef struct packed {
    logic              is_hdr;
    logic [15:0]       word;
    logic              last;
    logic [1:0]        bytes;
    logic [47:0]       mac;
    logic [15:0]       csum;
    logic [HCNT_W-1:0] hwords;
  } q_entry_t;

  typedef struct packed {
    logic              en;
    logic [HCNT_W-1:0] addr;
    logic [15:0]       data;
  } hdr_wr_t;

  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ipv4ff_queue.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_frame_forwarder_defines.svh"

module ipv4ff_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ipv4ff_pkg::q_entry_t data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output ipv4ff_pkg::q_entry_t     data_o,
  output logic                     empty_o
);

  ipv4ff_pkg::q_entry_t               mem_q [ipv4ff_pkg::QDEPTH];
  logic [ipv4ff_pkg::QPTR_W-1:0]      wptr_q, rptr_q;
  logic [ipv4ff_pkg::QCNT_W-1:0]      cnt_q;

  assign full_o  = (cnt_q == ipv4ff_pkg::QCNT_W'(ipv4ff_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == ipv4ff_pkg::QPTR_W'(ipv4ff_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == ipv4ff_pkg::QPTR_W'(ipv4ff_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `FWD_NEVER(a_q_overflow, push_i && full_o && !pop_i, "word pushed into full queue")
  `FWD_NEVER(a_q_underflow, pop_i && empty_o, "word popped from empty queue")
  `FWD_ASSERT(a_q_bound, cnt_q <= ipv4ff_pkg::QCNT_W'(ipv4ff_pkg::QDEPTH), "queue count past depth")

endmodule

`default_nettype wire

>>> hw/rtl/ipv4ff_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv4ff_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ipv4ff_pkg::in_item_t in_item_i,
  output logic                      q_push_o,
  output ipv4ff_pkg::q_entry_t      q_data_o,
  input  wire logic                 q_full_i,
  input  wire logic                 hdr_done_i,
  output ipv4ff_pkg::hdr_wr_t       mem_wr_o
);

  localparam int W = ipv4ff_pkg::HCNT_W;

  ipv4ff_pkg::front_state_e state_q, state_d;
  logic [W-1:0]  wc_q, wc_d;
  logic [W-1:0]  hw_q, hw_d;
  logic [15:0]   acc_q, acc_d;
  logic [31:0]   dst_q, dst_d;
  logic          last_q, last_d;
  logic          busy_q, busy_d;
  logic [ipv4ff_pkg::ROUTE_ENTRIES-1:0] hitv_q;

  logic [31:0]   rdest_q  [ipv4ff_pkg::ROUTE_ENTRIES];
  logic [47:0]   rmac_q   [ipv4ff_pkg::ROUTE_ENTRIES];
  logic [ipv4ff_pkg::ROUTE_ENTRIES-1:0] ruse_q;

  logic          ready;
  logic          accept;

  always_comb begin
    case (state_q)
      ipv4ff_pkg::F_COLLECT: ready = (in_item_i.action == ipv4ff_pkg::ACT_ROUTE) || !busy_q;
      ipv4ff_pkg::F_PASS:    ready = (in_item_i.action == ipv4ff_pkg::ACT_ROUTE) || !q_full_i;
      ipv4ff_pkg::F_DROP:    ready = 1'b1;
      default:               ready = 1'b0;
    endcase
  end

  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  always_comb begin
    logic [W-1:0]  cnt;
    logic [W-1:0]  hw_new;
    logic [W-1:0]  hw_eff;
    logic [15:0]   term;
    logic [15:0]   acc_in;
    logic          found;
    logic [47:0]   mac;
    logic          lst;
    logic [15:0]   wd;

    state_d  = state_q;
    wc_d     = wc_q;
    hw_d     = hw_q;
    acc_d    = acc_q;
    dst_d    = dst_q;
    last_d   = last_q;
    busy_d   = busy_q && !hdr_done_i;
    q_push_o = 1'b0;
    q_data_o = '0;
    mem_wr_o = '0;
    lst      = in_item_i.word_last;
    wd       = in_item_i.frame_word;
    cnt      = wc_q + 1'b1;
    hw_new   = ipv4ff_pkg::ETH_WORDS + W'({wd[11:8], 1'b0});
    hw_eff   = (wc_q == ipv4ff_pkg::IDX_IHL) ? hw_new : hw_q;
    acc_in   = (wc_q == ipv4ff_pkg::ETH_WORDS) ? 16'd0 : acc_q;
    term     = wd;
    found    = 1'b0;
    mac      = '0;
    if (wc_q == ipv4ff_pkg::IDX_TTL) begin
      term = {wd[15:8] - 8'd1, wd[7:0]};
    end else if (wc_q == ipv4ff_pkg::IDX_CSUM) begin
      term = 16'd0;
    end
    for (int i = ipv4ff_pkg::ROUTE_ENTRIES - 1; i >= 0; i--) begin
      if (hitv_q[i]) begin
        found = 1'b1;
        mac   = rmac_q[i];
      end
    end

    case (state_q)
      ipv4ff_pkg::F_PASS: begin
        if (accept && in_item_i.action == ipv4ff_pkg::ACT_FRAME) begin
          q_push_o       = 1'b1;
          q_data_o.word  = wd;
          q_data_o.last  = lst;
          q_data_o.bytes = (lst && in_item_i.last_bytes == ipv4ff_pkg::BYTES_ONE) ?
                           ipv4ff_pkg::BYTES_ONE : ipv4ff_pkg::BYTES_TWO;
          if (lst) begin
            state_d = ipv4ff_pkg::F_COLLECT;
            wc_d    = '0;
          end
        end
      end
      ipv4ff_pkg::F_DROP: begin
        if (accept && in_item_i.action == ipv4ff_pkg::ACT_FRAME && lst) begin
          state_d = ipv4ff_pkg::F_COLLECT;
          wc_d    = '0;
        end
      end
      ipv4ff_pkg::F_COLLECT: begin
        if (accept && in_item_i.action == ipv4ff_pkg::ACT_FRAME) begin
          mem_wr_o.en   = 1'b1;
          mem_wr_o.addr = wc_q;
          mem_wr_o.data = wd;
          wc_d          = cnt;
          if (wc_q >= ipv4ff_pkg::ETH_WORDS) begin
            acc_d = ipv4ff_pkg::oc_add(acc_in, term);
          end
          if (wc_q == ipv4ff_pkg::IDX_DST_HI) begin
            dst_d[31:16] = wd;
          end
          if (wc_q == ipv4ff_pkg::IDX_DST_LO) begin
            dst_d[15:0] = wd;
          end
          if ((wc_q == ipv4ff_pkg::IDX_TYPE && wd != ipv4ff_pkg::ETH_TYPE_IPV4) ||
              (wc_q == ipv4ff_pkg::IDX_IHL && wd[11:8] < ipv4ff_pkg::IHL_MIN)) begin
            // bad type or short IHL: drop rest of frame
            wc_d    = '0;
            state_d = lst ? ipv4ff_pkg::F_COLLECT : ipv4ff_pkg::F_DROP;
          end else begin
            if (wc_q == ipv4ff_pkg::IDX_IHL) begin
              hw_d = hw_new;
            end
            if (cnt <= ipv4ff_pkg::ETH_WORDS || cnt < hw_eff) begin
              if (lst) begin
                wc_d = '0;
              end
            end else if (lst && in_item_i.last_bytes != ipv4ff_pkg::BYTES_TWO) begin
              wc_d = '0;
            end else begin
              wc_d    = '0;
              last_d  = lst;
              state_d = ipv4ff_pkg::F_LOOK;
            end
          end
        end
      end
      ipv4ff_pkg::F_LOOK: begin
        state_d = ipv4ff_pkg::F_ISSUE;
      end
      ipv4ff_pkg::F_ISSUE: begin
        if (!found) begin
          state_d = last_q ? ipv4ff_pkg::F_COLLECT : ipv4ff_pkg::F_DROP;
        end else if (!q_full_i) begin
          q_push_o        = 1'b1;
          q_data_o.is_hdr = 1'b1;
          q_data_o.last   = last_q;
          q_data_o.bytes  = ipv4ff_pkg::BYTES_TWO;
          q_data_o.mac    = mac;
          q_data_o.csum   = ~acc_q;
          q_data_o.hwords = hw_q;
          busy_d          = 1'b1;
          state_d         = last_q ? ipv4ff_pkg::F_COLLECT : ipv4ff_pkg::F_PASS;
        end
      end
      default: begin
        state_d = ipv4ff_pkg::F_DROP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipv4ff_pkg::F_COLLECT;
      wc_q    <= '0;
      hw_q    <= '0;
      busy_q  <= 1'b0;
      ruse_q  <= '0;
    end else begin
      state_q <= state_d;
      wc_q    <= wc_d;
      hw_q    <= hw_d;
      busy_q  <= busy_d;
      if (accept && in_item_i.action == ipv4ff_pkg::ACT_ROUTE) begin
        for (int i = 0; i < ipv4ff_pkg::ROUTE_ENTRIES; i++) begin
          if (int'(in_item_i.route_index) == i) begin
            ruse_q[i] <= in_item_i.route_valid;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    dst_q  <= dst_d;
    last_q <= last_d;
    if (accept && in_item_i.action == ipv4ff_pkg::ACT_ROUTE) begin
      for (int i = 0; i < ipv4ff_pkg::ROUTE_ENTRIES; i++) begin
        if (int'(in_item_i.route_index) == i) begin
          rdest_q[i] <= in_item_i.route_addr;
          rmac_q[i]  <= in_item_i.route_mac;
        end
      end
    end
    // one compare per entry, registered; picked next cycle
    for (int i = 0; i < ipv4ff_pkg::ROUTE_ENTRIES; i++) begin
      hitv_q[i] <= ruse_q[i] && (rdest_q[i] == dst_q);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ipv4ff_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "ipv4_frame_forwarder_defines.svh"

module ipv4ff_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_empty_i,
  input  wire ipv4ff_pkg::q_entry_t  q_data_i,
  output logic                       q_pop_o,
  input  wire ipv4ff_pkg::hdr_wr_t   mem_wr_i,
  input  wire logic [47:0]           own_mac_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output ipv4ff_pkg::out_item_t      out_item_o,
  output logic                       hdr_done_o
);

  localparam int W = ipv4ff_pkg::HCNT_W;

  ipv4ff_pkg::back_state_e state_q, state_d;
  ipv4ff_pkg::q_entry_t    cmd_q, cmd_d;
  logic [W-1:0]            k_q, k_d;
  logic [15:0]             mem [ipv4ff_pkg::HDR_MAX];
  logic [15:0]             rdata_q;
  logic                    rd_en;
  logic                    out_valid_q;
  ipv4ff_pkg::out_item_t   out_q;
  logic                    out_free;
  logic                    load;
  ipv4ff_pkg::out_item_t   load_item;
  logic [15:0]             sub;
  logic                    k_end;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign k_end       = (k_q == cmd_q.hwords - 1'b1);

  // header word k, rewritten on the fly
  always_comb begin
    sub = rdata_q;
    if (k_q == W'(0)) begin
      sub = cmd_q.mac[47:32];
    end else if (k_q == W'(1)) begin
      sub = cmd_q.mac[31:16];
    end else if (k_q == W'(2)) begin
      sub = cmd_q.mac[15:0];
    end else if (k_q == ipv4ff_pkg::IDX_SMAC0) begin
      sub = own_mac_i[47:32];
    end else if (k_q == ipv4ff_pkg::IDX_SMAC0 + 1'b1) begin
      sub = own_mac_i[31:16];
    end else if (k_q == ipv4ff_pkg::IDX_SMAC0 + W'(2)) begin
      sub = own_mac_i[15:0];
    end else if (k_q == ipv4ff_pkg::IDX_TYPE) begin
      sub = ipv4ff_pkg::ETH_TYPE_IPV4;
    end else if (k_q == ipv4ff_pkg::IDX_TTL) begin
      sub = {rdata_q[15:8] - 8'd1, rdata_q[7:0]};
    end else if (k_q == ipv4ff_pkg::IDX_CSUM) begin
      sub = cmd_q.csum;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    k_d        = k_q;
    q_pop_o    = 1'b0;
    rd_en      = 1'b0;
    load       = 1'b0;
    load_item  = '0;
    hdr_done_o = 1'b0;
    case (state_q)
      ipv4ff_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i.is_hdr) begin
            q_pop_o = 1'b1;
            cmd_d   = q_data_i;
            k_d     = '0;
            state_d = ipv4ff_pkg::B_RD;
          end else if (out_free) begin
            q_pop_o              = 1'b1;
            load                 = 1'b1;
            load_item.out_word  = q_data_i.word;
            load_item.out_last  = q_data_i.last;
            load_item.out_bytes = q_data_i.bytes;
          end
        end
      end
      ipv4ff_pkg::B_RD: begin
        rd_en   = 1'b1;
        state_d = ipv4ff_pkg::B_WR;
      end
      ipv4ff_pkg::B_WR: begin
        if (out_free) begin
          load                 = 1'b1;
          load_item.out_word  = sub;
          load_item.out_last  = cmd_q.last && k_end;
          load_item.out_bytes = ipv4ff_pkg::BYTES_TWO;
          if (k_end) begin
            hdr_done_o = 1'b1;
            state_d    = ipv4ff_pkg::B_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ipv4ff_pkg::B_RD;
          end
        end
      end
      default: begin
        state_d = ipv4ff_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipv4ff_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_free) begin
        out_valid_q <= load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    k_q   <= k_d;
    if (load) begin
      out_q <= load_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem[mem_wr_i.addr] <= mem_wr_i.data;
    end
    if (rd_en) begin
      rdata_q <= mem[k_q];
    end
  end

  `FWD_NEVER(a_hdr_not_overwritten, mem_wr_i.en && (state_q != ipv4ff_pkg::B_IDLE), "header buffer written during burst")

endmodule

`default_nettype wire

>>> hw/rtl/ipv4_frame_forwarder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake                  payload
// in        in   in_valid_i / in_stall_o    in_item_i  (frame word or route write)
// out       out  out_valid_o / out_stall_i  out_item_o (forwarded frame word)
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_data_i (own MAC)
//
// Route writes and payload words go at one word per cycle when nothing stalls.
// Header words go at one per cycle while no header burst is pending; a completed
// header goes through route lookup; the back end emits each word by buffer read, then output.
// A new frame's header waits until the previous header burst has left the buffer.
// Reset clears control state, route valid bits and own MAC; no clearing pass.
// Either side may stall independently; a 4-entry queue separates them.

module ipv4_frame_forwarder (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ipv4ff_pkg::in_item_t in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ipv4ff_pkg::out_item_t     out_item_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [47:0]          cfg_data_i
);

  logic [47:0]          own_mac_q;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  ipv4ff_pkg::q_entry_t q_wdata;
  ipv4ff_pkg::q_entry_t q_rdata;
  ipv4ff_pkg::hdr_wr_t  mem_wr;
  logic                 hdr_done;

  // config is to be written only while idle (the user must keep to this; the block does not enforce it); always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      own_mac_q <= cfg_data_i;
    end
  end

  // front: parse, buffer header, checksum, route lookup
  ipv4ff_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .q_full_i   (q_full),
    .hdr_done_i (hdr_done),
    .mem_wr_o   (mem_wr)
  );

  ipv4ff_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // back: header burst with rewrite, payload pass-through, output register
  ipv4ff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .mem_wr_i    (mem_wr),
    .own_mac_i   (own_mac_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .hdr_done_o  (hdr_done)
  );

endmodule

`default_nettype wire

>>> tb/sv/ipv4_frame_forwarder_test.sv
`timescale 1ns / 1ps

module ipv4_frame_forwarder_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] PH_COLLECT = 2'd0;
  localparam logic [1:0] PH_PASS    = 2'd1;
  localparam logic [1:0] PH_DROP    = 2'd2;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  ipv4ff_pkg::in_item_t  in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  ipv4ff_pkg::out_item_t out_item_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [47:0]           cfg_data_i = '0;

  ipv4_frame_forwarder dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // forwarder state as the testbench sees it
  logic [15:0] hdr_buf [ipv4ff_pkg::HDR_MAX];
  int          hdr_cnt;
  int          hdr_len;
  logic [1:0]  phase;
  logic [31:0] rt_addr [ipv4ff_pkg::ROUTE_ENTRIES];
  logic [47:0] rt_mac [ipv4ff_pkg::ROUTE_ENTRIES];
  logic        rt_on [ipv4ff_pkg::ROUTE_ENTRIES];
  logic [47:0] src_mac;

  ipv4ff_pkg::out_item_t words_due[$];
  int          errors = 0;
  int          words_seen = 0;
  int          frames_sent = 0;
  longint      cycles = 0;
  bit          send_idle = 1'b1;   // random gaps on the input side
  bit          recv_idle = 1'b1;   // random stalls on the output side
  int          hold_off = 0;       // forced output stall, in cycles

  function automatic void push_word(logic [15:0] w, logic l, logic [1:0] b);
    ipv4ff_pkg::out_item_t o;
    o.out_word = w; o.out_last = l; o.out_bytes = b;
    words_due.push_back(o);
  endfunction

  function automatic void close_frame(logic l);
    hdr_cnt = 0;
    phase = l ? PH_COLLECT : PH_DROP;
  endfunction

  // expected output words, or route table update, for one accepted input word
  function automatic void forward_word(ipv4ff_pkg::in_item_t it);
    int hit;
    logic [31:0] dst, sum;
    logic [47:0] m;
    logic [15:0] w;
    hit = -1;
    if (it.action == ipv4ff_pkg::ACT_ROUTE) begin
      rt_addr[it.route_index] = it.route_addr;
      rt_mac[it.route_index] = it.route_mac;
      rt_on[it.route_index] = it.route_valid;
      return;
    end
    if (phase == PH_PASS) begin
      if (it.word_last) begin
        phase = PH_COLLECT;
        hdr_cnt = 0;
      end
      push_word(it.frame_word, it.word_last,
                (it.word_last && it.last_bytes == ipv4ff_pkg::BYTES_ONE) ?
                ipv4ff_pkg::BYTES_ONE : ipv4ff_pkg::BYTES_TWO);
      return;
    end
    if (phase != PH_COLLECT) begin
      if (it.word_last) begin
        phase = PH_COLLECT;
        hdr_cnt = 0;
      end
      return;
    end
    if (hdr_cnt >= ipv4ff_pkg::HDR_MAX) begin
      close_frame(it.word_last);
      return;
    end
    hdr_buf[hdr_cnt] = it.frame_word;
    hdr_cnt++;
    if (hdr_cnt == 7 && it.frame_word != ipv4ff_pkg::ETH_TYPE_IPV4) begin
      close_frame(it.word_last);
      return;
    end
    if (hdr_cnt == 8) begin
      if (it.frame_word[11:8] < ipv4ff_pkg::IHL_MIN) begin
        close_frame(it.word_last);
        return;
      end
      hdr_len = 7 + 2 * it.frame_word[11:8];
    end
    if (hdr_cnt <= 7 || hdr_cnt < hdr_len) begin
      if (it.word_last) close_frame(1'b1);
      return;
    end
    if (it.word_last && it.last_bytes != ipv4ff_pkg::BYTES_TWO) begin
      close_frame(1'b1);
      return;
    end
    dst = {hdr_buf[15], hdr_buf[16]};
    for (int i = 0; i < ipv4ff_pkg::ROUTE_ENTRIES; i++)
      if (hit < 0 && rt_on[i] && rt_addr[i] == dst) hit = i;
    if (hit < 0) begin
      close_frame(it.word_last);
      return;
    end
    m = rt_mac[hit];
    hdr_buf[0] = m[47:32]; hdr_buf[1] = m[31:16]; hdr_buf[2] = m[15:0];
    hdr_buf[3] = src_mac[47:32]; hdr_buf[4] = src_mac[31:16]; hdr_buf[5] = src_mac[15:0];
    hdr_buf[6] = ipv4ff_pkg::ETH_TYPE_IPV4;
    w = hdr_buf[11];
    hdr_buf[11] = {w[15:8] - 8'd1, w[7:0]};
    hdr_buf[12] = '0;
    sum = 0;
    for (int i = 7; i < hdr_len; i++) sum += hdr_buf[i];
    sum = (sum >> 16) + (sum & 32'hFFFF);
    sum += sum >> 16;
    hdr_buf[12] = ~sum[15:0];
    for (int k = 0; k < hdr_len; k++)
      push_word(hdr_buf[k], it.word_last && k == hdr_len - 1, ipv4ff_pkg::BYTES_TWO);
    hdr_cnt = 0;
    phase = it.word_last ? PH_COLLECT : PH_PASS;
  endfunction

  // output side: checking and timeout
  always @(posedge clk_i) begin
    ipv4ff_pkg::out_item_t exp_w;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen <= words_seen + 1;
      if (words_due.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected word, expected none, actual %h", $time, out_item_o);
      end else begin
        exp_w = words_due.pop_front();
        if (out_item_o.out_word !== exp_w.out_word ||
            out_item_o.out_last !== exp_w.out_last ||
            out_item_o.out_bytes !== exp_w.out_bytes) begin
          errors <= errors + 1;
          $display("%0t: word mismatch, expected %h/%b/%0d actual %h/%b/%0d", $time,
                   exp_w.out_word, exp_w.out_last, exp_w.out_bytes,
                   out_item_o.out_word, out_item_o.out_last, out_item_o.out_bytes);
        end
      end
    end
  end

  // long hold-off counted here, otherwise random stalls while recv_idle is set
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= recv_idle && ($urandom_range(99) < 12);
    end
  end

  // valid stays up after the accepting edge so the next word can follow at once;
  // wait_drained drops it
  task automatic send_word(ipv4ff_pkg::in_item_t it);
    while (send_idle && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    forward_word(it);
  endtask

  task automatic send_route(int idx, logic [31:0] a, logic [47:0] m, logic v);
    ipv4ff_pkg::in_item_t it;
    it = '0;
    it.action = ipv4ff_pkg::ACT_ROUTE;
    it.route_index = idx[3:0]; it.route_addr = a; it.route_mac = m; it.route_valid = v;
    it.frame_word = 16'($urandom); it.word_last = 1'($urandom);
    it.last_bytes = 2'($urandom);
    send_word(it);
  endtask

  task automatic send_frame_word(logic [15:0] w, logic l, logic [1:0] b);
    ipv4ff_pkg::in_item_t it;
    it = '0;
    it.action = ipv4ff_pkg::ACT_FRAME;
    it.frame_word = w; it.word_last = l; it.last_bytes = b;
    it.route_index = 4'($urandom); it.route_addr = $urandom;
    it.route_mac = 48'({$urandom, $urandom}); it.route_valid = 1'($urandom);
    send_word(it);
  endtask

  // one frame: destination, ihl, type, TTL, payload length, last bytes and cut chosen by the caller
  task automatic send_frame(logic [31:0] dst, logic [3:0] ihl, logic [15:0] etype,
                            logic [7:0] ttl, int pay, logic [1:0] lb, int cut);
    logic [15:0] f [$];
    int n;
    frames_sent++;
    for (int i = 0; i < 6; i++) f.push_back(16'($urandom));
    f.push_back(etype);
    f.push_back({4'h4, ihl, 8'($urandom)});
    f.push_back(16'($urandom)); f.push_back(16'($urandom)); f.push_back(16'($urandom));
    f.push_back({ttl, 8'($urandom)});
    f.push_back(16'($urandom));
    f.push_back(16'($urandom)); f.push_back(16'($urandom));
    f.push_back(dst[31:16]); f.push_back(dst[15:0]);
    for (int i = 5; i < ihl; i++) begin
      f.push_back(16'($urandom)); f.push_back(16'($urandom));
    end
    for (int i = 0; i < pay; i++) f.push_back(16'($urandom));
    n = (cut > 0 && cut < f.size()) ? cut : f.size();
    for (int i = 0; i < n; i++)
      send_frame_word(f[i], i == n - 1, (i == n - 1) ? lb : ipv4ff_pkg::BYTES_TWO);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_own_mac(logic [47:0] m);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    src_mac = m;
  endtask

  task automatic test_routes();
    send_route(0, 32'h0A000001, 48'h0011_2233_4455, 1'b1);
    send_route(1, 32'hFFFFFFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_route(2, 32'h00000000, 48'h0, 1'b1);
    send_route(3, 32'h0A000001, 48'hAAAA_BBBB_CCCC, 1'b1);
    send_route(15, 32'hC0A80101, 48'h1234_5678_9ABC, 1'b1);
    send_route(14, 32'hDEADBEEF, 48'h5555_5555_5555, 1'b0);
  endtask

  task automatic test_directed();
    // first frames with no gaps and no stalls on either side
    send_idle = 1'b0; recv_idle = 1'b0;
    send_frame(32'h0A000001, 4'd5, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd64, 2,
               ipv4ff_pkg::BYTES_TWO, 0);
    send_frame(32'hFFFFFFFF, 4'd15, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd0, 2,
               ipv4ff_pkg::BYTES_ONE, 0);
    send_frame(32'h00000000, 4'd5, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd255, 0,
               ipv4ff_pkg::BYTES_TWO, 0);
    send_frame(32'hC0A80101, 4'd6, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd1, 0,
               ipv4ff_pkg::BYTES_ONE, 0);
    send_idle = 1'b1; recv_idle = 1'b1;
    send_frame(32'hC0A80101, 4'd5, 16'h86DD, 8'd9, 0, ipv4ff_pkg::BYTES_TWO, 0);
    send_frame(32'hC0A80101, 4'd4, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd9, 0,
               ipv4ff_pkg::BYTES_TWO, 0);
    send_frame(32'hC0A80101, 4'd0, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd9, 0,
               ipv4ff_pkg::BYTES_TWO, 0);
    send_frame(32'hC0A80101, 4'd5, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd9, 2,
               ipv4ff_pkg::BYTES_TWO, 10);
    send_frame(32'hDEADBEEF, 4'd5, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd9, 0,
               ipv4ff_pkg::BYTES_TWO, 0);
    send_frame(32'h12345678, 4'd5, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd9, 0,
               ipv4ff_pkg::BYTES_TWO, 0);
    send_frame(32'h0A000001, 4'd5, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd9, 1, 2'd3, 0);
    send_frame(32'h0A000001, 4'd5, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd9, 1, 2'd0, 0);
  endtask

  task automatic test_random(int n);
    logic [31:0] dst;
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        send_route(int'($urandom_range(15)),
                   $urandom_range(1) ? rt_addr[$urandom_range(15)] : 32'($urandom),
                   48'({$urandom, $urandom}), 1'($urandom_range(3) != 0));
        sent++;
      end else begin
        dst = ($urandom_range(9) < 8) ? rt_addr[$urandom_range(15)] : 32'($urandom);
        case ($urandom_range(9))
          0: send_frame(dst, 4'($urandom_range(4)), ipv4ff_pkg::ETH_TYPE_IPV4,
                        8'($urandom), 2, 2'($urandom), 0);
          1: send_frame(dst, 4'd5, 16'($urandom), 8'($urandom), 2, 2'($urandom), 0);
          2: send_frame(dst, 4'($urandom_range(15, 5)), ipv4ff_pkg::ETH_TYPE_IPV4,
                        8'($urandom), 3, 2'($urandom), int'($urandom_range(30, 1)));
          3: send_frame(dst, 4'($urandom_range(15, 5)), ipv4ff_pkg::ETH_TYPE_IPV4,
                        8'($urandom), 0, 2'($urandom), 0);
          default: send_frame(dst, 4'($urandom_range(7, 5)), ipv4ff_pkg::ETH_TYPE_IPV4,
                              8'($urandom), int'($urandom_range(6)), 2'($urandom), 0);
        endcase
        sent += 20;
      end
    end
  endtask

  // receiver holds off while a frame keeps coming, so the queue backs up
  task automatic test_backpressure();
    hold_off = 300;
    send_frame(32'h0A000001, 4'd5, ipv4ff_pkg::ETH_TYPE_IPV4, 8'd7, 8,
               ipv4ff_pkg::BYTES_ONE, 0);
    wait_drained();
  endtask

  initial begin
    phase = PH_COLLECT; hdr_cnt = 0; hdr_len = 0; src_mac = '0;
    for (int i = 0; i < ipv4ff_pkg::ROUTE_ENTRIES; i++) begin
      rt_addr[i] = '0; rt_mac[i] = '0; rt_on[i] = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_routes();
    test_directed();
    wait_drained();
    write_own_mac(48'hFFFF_FFFF_FFFF);
    test_backpressure();
    write_own_mac(48'h02A5_5A00_C3E1);
    test_random(20);
    wait_drained();
    $display("Covered %0d frames with route writes, drops, short headers and stalls;",
             frames_sent);
    $display("%0d forwarded words checked against the predicted rewrite.", words_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ipv4ff_pkg.sv
hw/rtl/ipv4ff_queue.sv
hw/rtl/ipv4ff_front.sv
hw/rtl/ipv4ff_back.sv
hw/rtl/ipv4_frame_forwarder.sv
tb/sv/ipv4_frame_forwarder_test.sv
